// File: hdl/rms_pkg.sv
// Shared types and constants for the rolling mean and deviation block.
// No dependencies; rms_ring, rolling_mean_std and the testbench refer to it by scoped names.
`default_nettype none
package rms_pkg;

   localparam int SAMPLE_W = 24;
   localparam int WIN_W = 7;
   localparam int OUT_W = 32;
   localparam int WINDOW_MAX_DEF = 64;
   localparam int FRACTION_BITS_DEF = 8;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd10;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_SQ,
      S_MAGS,
      S_MAG,
      S_DIVS,
      S_DIV,
      S_ROOTS,
      S_ROOT,
      S_FIN
   } state_type;

endpackage
`default_nettype wire

// File: hdl/rms_ring.sv
// Sample history memory with one write port and one registered read port.
// Uses rms_pkg for the sample width.
`default_nettype none
module rms_ring #(
   parameter int DEPTH = rms_pkg::WINDOW_MAX_DEF,
   parameter int AW = $clog2(DEPTH)
) (
   input  wire                               clock,
   input  wire                               wr_en,
   input  wire  [AW-1:0]                     wr_addr,
   input  wire  [rms_pkg::SAMPLE_W-1:0]      wr_data,
   input  wire                               rd_en,
   input  wire  [AW-1:0]                     rd_addr,
   output logic [rms_pkg::SAMPLE_W-1:0]      rd_data
);

   logic [rms_pkg::SAMPLE_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/rms_mul.sv
// Bit-serial shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Standalone; done is registered at the same edge as the last step, so it rises with the final product.
`default_nettype none
module rms_mul #(
   parameter int AW_ = 24,
   parameter int BW_ = 24
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire  [AW_-1:0]         a,
   input  wire  [BW_-1:0]         b,
   output logic [AW_+BW_-1:0]     product,
   output logic                   done
);

   localparam int PW = AW_ + BW_;
   localparam int CNTW = $clog2(BW_ + 1);

   logic [PW-1:0]   mcand_ff;
   logic [BW_-1:0]  mplier_ff;
   logic [PW-1:0]   acc_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            done_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= PW'(a);
         mplier_ff <= b;
         acc_ff    <= '0;
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNTW'(BW_);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNTW'(1));
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNTW'(1);
         end
      end
   end

   assign product = acc_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// File: hdl/rms_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; the quotient holds until the next start.
`default_nettype none
module rms_div #(
   parameter int NUMW = 76,
   parameter int DENW = 14
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire  [NUMW-1:0]      numer,
   input  wire  [DENW-1:0]      denom,
   output logic [NUMW-1:0]      quot,
   output logic                 done
);

   localparam int CNTW = $clog2(NUMW + 1);

   logic [NUMW-1:0] sh_ff;
   logic [DENW-1:0] rem_ff;
   logic [DENW-1:0] den_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            done_ff;
   logic [DENW:0]   trial;
   logic            fits;

   always_comb begin
      trial = {rem_ff, sh_ff[NUMW-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? DENW'(trial - {1'b0, den_ff}) : DENW'(trial);
         sh_ff  <= {sh_ff[NUMW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNTW'(NUMW);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNTW'(1));
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNTW'(1);
         end
      end
   end

   assign quot = sh_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// File: hdl/rms_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Standalone; the root is the floor of the exact root.
`default_nettype none
module rms_sqrt #(
   parameter int INW = 76,
   parameter int RTW = (INW + 1) / 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire  [INW-1:0]      radicand,
   output logic [RTW-1:0]      root,
   output logic                done
);

   localparam int EW = 2 * RTW;
   localparam int REMW = RTW + 2;
   localparam int CNTW = $clog2(RTW + 1);

   logic [EW-1:0]   sh_ff;
   logic [REMW-1:0] rem_ff;
   logic [RTW-1:0]  root_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            done_ff;
   logic [REMW+1:0] trial;
   logic [REMW+1:0] test;
   logic            fits;

   always_comb begin
      trial = {rem_ff, sh_ff[EW-1:EW-2]};
      test  = (REMW + 2)'({root_ff, 2'b01});
      fits  = trial >= test;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff   <= EW'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= fits ? REMW'(trial - test) : REMW'(trial);
         root_ff <= {root_ff[RTW-2:0], fits};
         sh_ff   <= sh_ff << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNTW'(RTW);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNTW'(1));
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNTW'(1);
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// File: hdl/rolling_mean_std.sv
// Each item passes in turn through the bit-serial multipliers, the restoring
// dividers and the root unit.
// Throughput: one item at a time; the next item is taken once the current one has
// moved into the output register. Synchronous active-high reset clears control
// state, sets the window to ten and empties the sums; the history memory is not
// cleared, and only entries written since the last clear are ever used.
`default_nettype none
module rolling_mean_std #(
   parameter int WINDOW_MAX = rms_pkg::WINDOW_MAX_DEF,
   parameter int FRACTION_BITS = rms_pkg::FRACTION_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,    // [23:0] sample
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,    // [31:0] mean_value, [63:32] std_value
   output logic [1:0]  rsp_tuser,    // [0] mean_valid, [1] std_valid
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [6:0]  csr_data      // [6:0] window_length
);

   localparam int SW = rms_pkg::SAMPLE_W;
   localparam int CW = rms_pkg::WIN_W;
   localparam int OW = rms_pkg::OUT_W;
   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int PW2 = AW + 2;
   localparam int SCW = $clog2(WINDOW_MAX + 1);
   localparam int CMPW = (SCW > CW) ? SCW : CW;
   localparam int MAGW = SW + AW;
   localparam int SUMW = MAGW + 1;
   localparam int SQW = 2 * SW - 1 + AW;
   localparam int DW = ((SQW + CW) > (2 * MAGW)) ? (SQW + CW) : (2 * MAGW);
   localparam int NW = DW + 2 * FRACTION_BITS;
   localparam int DENW = 2 * CW;
   localparam int RTW = (NW + 1) / 2;
   localparam int XW = (RTW > OW) ? RTW : OW + 1;

   rms_pkg::state_type state_ff, state_in;

   logic [CW-1:0]          win_ff;
   logic [AW-1:0]          wp_ff;
   logic [SCW-1:0]         seen_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic [SQW-1:0]         sq_ff;
   logic signed [SW-1:0]   samp_ff;
   logic                   rm_ff;
   logic                   mok_ff;
   logic                   sok_ff;
   logic                   rsp_valid_ff;
   logic [63:0]            rsp_data_ff;
   logic [1:0]             rsp_user_ff;

   logic                   accept;
   logic                   in_range;
   logic                   enough;
   logic [PW2-1:0]         rd_tmp;
   logic [AW-1:0]          rd_addr;
   logic [SW-1:0]          old_raw;
   logic signed [SW-1:0]   old_s;
   logic [SW-1:0]          samp_mag;
   logic [SW-1:0]          old_mag;
   logic [MAGW-1:0]        sum_mag;
   logic                   sum_neg;
   logic                   start_sq, start_mag, start_div, start_root, out_load;
   logic [2*SW-1:0]        p_new, p_old;
   logic [2*MAGW-1:0]      p_mag;
   logic [SQW+MAGW-1:0]    p_wsq;
   logic                   dn_new, dn_old, dn_mag, dn_wsq, dn_sd, dn_md, dn_rt;
   logic [DW-1:0]          diff;
   logic [NW-1:0]          num_sd, num_md, q_sd, q_md;
   logic [DENW-1:0]        den_sd, den_md;
   logic [RTW-1:0]         root;
   logic [XW-1:0]          root_x;
   logic [OW-1:0]          mean_out, std_out;

   assign req_tready = (state_ff == rms_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_range = (win_ff != '0) && (CMPW'(win_ff) <= CMPW'(WINDOW_MAX));
      enough   = CMPW'(seen_ff) >= CMPW'(win_ff);
      rd_tmp   = PW2'(wp_ff) + PW2'(WINDOW_MAX) - PW2'(win_ff);
      if (rd_tmp >= PW2'(WINDOW_MAX)) begin
         rd_addr = AW'(rd_tmp - PW2'(WINDOW_MAX));
      end else begin
         rd_addr = AW'(rd_tmp);
      end
      old_s    = signed'(old_raw);
      samp_mag = samp_ff[SW-1] ? SW'(-samp_ff) : SW'(samp_ff);
      old_mag  = old_s[SW-1] ? SW'(-old_s) : SW'(old_s);
      sum_neg  = sum_ff[SUMW-1];
      sum_mag  = sum_neg ? MAGW'(-sum_ff) : MAGW'(sum_ff);
      diff     = DW'(p_wsq) - DW'(p_mag);
      num_sd   = NW'(diff) << (2 * FRACTION_BITS);
      num_md   = NW'(sum_mag) << FRACTION_BITS;
      den_sd   = DENW'(win_ff) * DENW'(win_ff - CW'(1));
      den_md   = DENW'(win_ff);
   end

   rms_ring #(.DEPTH(WINDOW_MAX), .AW(AW)) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (old_raw)
   );

   rms_mul #(.AW_(SW), .BW_(SW)) u_mul_new (
      .clock(clock), .reset(reset), .start(start_sq),
      .a(samp_mag), .b(samp_mag), .product(p_new), .done(dn_new)
   );

   rms_mul #(.AW_(SW), .BW_(SW)) u_mul_old (
      .clock(clock), .reset(reset), .start(start_sq),
      .a(old_mag), .b(old_mag), .product(p_old), .done(dn_old)
   );

   rms_mul #(.AW_(MAGW), .BW_(MAGW)) u_mul_mag (
      .clock(clock), .reset(reset), .start(start_mag),
      .a(sum_mag), .b(sum_mag), .product(p_mag), .done(dn_mag)
   );

   rms_mul #(.AW_(SQW), .BW_(MAGW)) u_mul_wsq (
      .clock(clock), .reset(reset), .start(start_mag),
      .a(sq_ff), .b(MAGW'(win_ff)), .product(p_wsq), .done(dn_wsq)
   );

   rms_div #(.NUMW(NW), .DENW(DENW)) u_div_sd (
      .clock(clock), .reset(reset), .start(start_div),
      .numer(num_sd), .denom(den_sd), .quot(q_sd), .done(dn_sd)
   );

   rms_div #(.NUMW(NW), .DENW(DENW)) u_div_md (
      .clock(clock), .reset(reset), .start(start_div),
      .numer(num_md), .denom(den_md), .quot(q_md), .done(dn_md)
   );

   rms_sqrt #(.INW(NW), .RTW(RTW)) u_sqrt (
      .clock(clock), .reset(reset), .start(start_root),
      .radicand(q_sd), .root(root), .done(dn_rt)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rms_pkg::S_IDLE:  if (accept) state_in = rms_pkg::S_LOAD;
         rms_pkg::S_LOAD:  state_in = rms_pkg::S_SQ;
         rms_pkg::S_SQ:    if (dn_new && dn_old) state_in = rms_pkg::S_MAGS;
         rms_pkg::S_MAGS:  state_in = rms_pkg::S_MAG;
         rms_pkg::S_MAG:   if (dn_mag && dn_wsq) state_in = rms_pkg::S_DIVS;
         rms_pkg::S_DIVS:  state_in = rms_pkg::S_DIV;
         rms_pkg::S_DIV:   if (dn_sd && dn_md) state_in = rms_pkg::S_ROOTS;
         rms_pkg::S_ROOTS: state_in = rms_pkg::S_ROOT;
         rms_pkg::S_ROOT:  if (dn_rt) state_in = rms_pkg::S_FIN;
         rms_pkg::S_FIN:   if (!rsp_valid_ff || rsp_tready) state_in = rms_pkg::S_IDLE;
         default:          state_in = rms_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      start_sq   = (state_ff == rms_pkg::S_LOAD);
      start_mag  = (state_ff == rms_pkg::S_MAGS);
      start_div  = (state_ff == rms_pkg::S_DIVS);
      start_root = (state_ff == rms_pkg::S_ROOTS);
      out_load   = (state_ff == rms_pkg::S_FIN) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      if (!sum_neg && (q_md > NW'(32'h7FFF_FFFF))) begin
         mean_out = 32'h7FFF_FFFF;
      end else if (sum_neg && (q_md > NW'(32'h8000_0000))) begin
         mean_out = 32'h8000_0000;
      end else begin
         mean_out = sum_neg ? OW'(-q_md) : OW'(q_md);
      end
      root_x = XW'(root);
      if (root_x > XW'(32'hFFFF_FFFF)) begin
         std_out = 32'hFFFF_FFFF;
      end else begin
         std_out = OW'(root_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rms_pkg::S_IDLE;
         win_ff       <= rms_pkg::WINDOW_RESET;
         wp_ff        <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            win_ff  <= csr_data;
            seen_ff <= '0;
            sum_ff  <= '0;
            sq_ff   <= '0;
         end else begin
            if (accept) begin
               wp_ff <= (wp_ff == AW'(WINDOW_MAX - 1)) ? '0 : wp_ff + AW'(1);
               if (seen_ff < SCW'(WINDOW_MAX)) begin
                  seen_ff <= seen_ff + SCW'(1);
               end
            end
            if ((state_ff == rms_pkg::S_LOAD) && in_range) begin
               sum_ff <= sum_ff + SUMW'(samp_ff) - (rm_ff ? SUMW'(old_s) : '0);
            end
            if ((state_ff == rms_pkg::S_SQ) && dn_new && in_range) begin
               sq_ff <= sq_ff + SQW'(p_new) - (rm_ff ? SQW'(p_old) : '0);
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         samp_ff <= signed'(req_tdata);
         rm_ff   <= in_range && enough;
      end
      if (state_ff == rms_pkg::S_LOAD) begin
         mok_ff <= in_range && enough;
         sok_ff <= in_range && enough && (win_ff >= CW'(2));
      end
      if (out_load) begin
         rsp_data_ff <= {sok_ff ? std_out : '0, mok_ff ? mean_out : '0};
         rsp_user_ff <= {sok_ff, mok_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// File: hdl/rms_checker.sv
// Port-level checks on the rolling mean and deviation block, bound to the top level.
// Depends on rolling_mean_std for its port names.
`default_nettype none
module rms_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata,
   input wire [1:0]  rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_std_needs_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser[1] || rsp_tuser[0]))
      else $error("deviation valid without mean valid");

   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("invalid mean is not zero");

   a_std_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[63:32] == 32'd0))
      else $error("invalid deviation is not zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind rolling_mean_std rms_checker u_rms_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// File: sim/tb_rolling_mean_std.sv
// Self-checking testbench for rolling_mean_std: windowed mean and sample deviation.
// Needs rms_pkg and rolling_mean_std; sends a directed table, then a fixed plan of windows with random samples.
`timescale 1ns / 100ps
`default_nettype none
module tb_rolling_mean_std;

   localparam int RING_DEPTH = rms_pkg::WINDOW_MAX_DEF;
   localparam int FRAC = rms_pkg::FRACTION_BITS_DEF;

   typedef struct packed {
      logic signed [31:0] mean_value;
      logic [31:0]        std_value;
      logic               mean_valid;
      logic               std_valid;
   } stats_t;

   typedef enum logic {ROW_WINDOW, ROW_SAMPLE} row_kind_t;

   typedef struct {
      row_kind_t   kind;
      int          value;
      bit          typed;
      logic [31:0] mean_value;
      logic [31:0] std_value;
      logic        mean_valid;
      logic        std_valid;
   } directed_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;

   rolling_mean_std uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Model state of the block.
   longint          history [RING_DEPTH];
   int              head_index = 0;
   int              fill_count = 0;
   longint          running_sum = 0;
   longint unsigned running_squares = 0;
   int              window_len = 10;

   stats_t stats_pending[$];
   int     mismatches = 0;
   int     samples_sent = 0;
   int     stats_checked = 0;
   int     windows_written = 0;
   int     tx_max_gap = 0;
   int     rx_max_gap = 0;

   directed_row_t directed_table [] = '{
      '{ROW_SAMPLE, 0,        1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 0,        1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 8388607,  1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_WINDOW, 1,        0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 8388607,  1, 32'h7FFFFF00, 32'h0,     1'b1, 1'b0},
      '{ROW_SAMPLE, -8388608, 1, 32'h80000000, 32'h0,     1'b1, 1'b0},
      '{ROW_WINDOW, 0,        0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 123,      1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, -1,       1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_WINDOW, 127,      0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 4660,     1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_WINDOW, 2,        0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 8388607,  1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, -8388608, 0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, -8388608, 0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_WINDOW, 3,        0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 100,      1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 200,      1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 300,      1, 32'd51200,    32'd25600, 1'b1, 1'b1},
      '{ROW_WINDOW, 64,       0, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, 7,        1, 32'h0,        32'h0,     1'b0, 1'b0},
      '{ROW_SAMPLE, -7,       1, 32'h0,        32'h0,     1'b0, 1'b0}
   };

   function automatic stats_t window_stats(input logic signed [23:0] sample);
      stats_t          res;
      longint          value;
      longint          oldest;
      longint unsigned magnitude;
      longint unsigned quotient;
      logic [127:0]    spread;
      logic [127:0]    scaled;
      logic [127:0]    root;
      logic [127:0]    trial;
      bit              in_range;
      bit              negative;
      value = sample;
      res = '0;
      in_range = window_len >= 1 && window_len <= RING_DEPTH;
      if (in_range) begin
         if (fill_count >= window_len) begin
            oldest = history[(head_index + RING_DEPTH - window_len) % RING_DEPTH];
            running_sum -= oldest;
            running_squares -= longint'(oldest * oldest);
         end
         running_sum += value;
         running_squares += longint'(value * value);
      end
      history[head_index] = value;
      head_index = (head_index + 1) % RING_DEPTH;
      if (fill_count < RING_DEPTH) fill_count++;
      res.mean_valid = in_range && fill_count >= window_len;
      res.std_valid = res.mean_valid && window_len >= 2;
      if (res.mean_valid) begin
         negative = running_sum < 0;
         magnitude = negative ? -running_sum : running_sum;
         quotient = (magnitude << FRAC) / window_len;
         if (!negative && quotient > 64'h7FFFFFFF) res.mean_value = 32'h7FFFFFFF;
         else if (negative && quotient > 64'h80000000) res.mean_value = 32'h80000000;
         else res.mean_value = negative ? -quotient[31:0] : quotient[31:0];
      end
      if (res.std_valid) begin
         magnitude = running_sum < 0 ? -running_sum : running_sum;
         spread = 128'(window_len) * 128'(running_squares) - 128'(magnitude) * 128'(magnitude);
         spread = spread << (2 * FRAC);
         scaled = spread / (128'(window_len) * 128'(window_len - 1));
         root = '0;
         for (int i = 63; i >= 0; i--) begin
            trial = root | (128'(1) << i);
            if (trial * trial <= scaled) root = trial;
         end
         res.std_value = root > 128'hFFFFFFFF ? 32'hFFFFFFFF : root[31:0];
      end
      return res;
   endfunction

   task automatic send_sample(input logic [23:0] sample, input bit typed, input stats_t typed_stats);
      int gap;
      stats_t predicted;
      gap = $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      do @(posedge clock); while (!req_tready);
      predicted = window_stats(sample);
      stats_pending.push_back(typed ? typed_stats : predicted);
      samples_sent++;
   endtask

   task automatic write_window(input logic [6:0] length);
      req_tvalid <= 1'b0;
      while (stats_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= length;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_len = length;
      fill_count = 0;
      running_sum = 0;
      running_squares = 0;
      windows_written++;
   endtask

   function automatic logic [23:0] draw_sample();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         1: return 24'($signed($urandom_range(0, 2000)) - 1000);
         2: return 24'h7FFFFF - 24'($urandom_range(0, 255));
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      stats_t typed_stats;
      int     window_plan [] = '{64, 5, 1, 2, 0, 127, 10, 37, 64, 3};
      int     phase_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_table[i]) begin
         if (directed_table[i].kind == ROW_WINDOW) begin
            write_window(7'(directed_table[i].value));
         end else begin
            typed_stats.mean_value = directed_table[i].mean_value;
            typed_stats.std_value = directed_table[i].std_value;
            typed_stats.mean_valid = directed_table[i].mean_valid;
            typed_stats.std_valid = directed_table[i].std_valid;
            send_sample(24'(directed_table[i].value), directed_table[i].typed, typed_stats);
         end
      end
      foreach (window_plan[p]) begin
         write_window(7'(window_plan[p]));
         tx_max_gap = (p % 3 == 1) ? 0 : 16;
         rx_max_gap = (p % 4 == 2) ? 0 : 16;
         phase_items = (window_plan[p] == 0 || window_plan[p] == 127) ? 12 : 55;
         repeat (phase_items) send_sample(draw_sample(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (stats_pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      $display("Sent %0d samples over %0d window settings; %0d results checked.",
               samples_sent, windows_written, stats_checked);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      stats_t expected;
      stats_t actual;
      int     gap;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, rx_max_gap);
         if (stats_checked == 150) gap = 400;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         actual.mean_value = rsp_tdata[31:0];
         actual.std_value = rsp_tdata[63:32];
         actual.mean_valid = rsp_tuser[0];
         actual.std_valid = rsp_tuser[1];
         stats_checked++;
         if (stats_pending.size() == 0) begin
            $error("Result arrived with no sample waiting for it");
            mismatches++;
         end else begin
            expected = stats_pending.pop_front();
            if (actual.mean_value !== expected.mean_value) begin
               $error("mean_value expected %0d got %0d",
                      expected.mean_value, actual.mean_value);
               mismatches++;
            end
            if (actual.std_value !== expected.std_value) begin
               $error("std_value expected %0d got %0d", expected.std_value, actual.std_value);
               mismatches++;
            end
            if (actual.mean_valid !== expected.mean_valid) begin
               $error("mean_valid expected %0b got %0b",
                      expected.mean_valid, actual.mean_valid);
               mismatches++;
            end
            if (actual.std_valid !== expected.std_valid) begin
               $error("std_valid expected %0b got %0b", expected.std_valid, actual.std_valid);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
